[src/btrs_pkg.sv]
// Shared constants, types and command codes of the binary trie rank/select unit.
package btrs_pkg;

  // Sizing of the trie and of the entry pool
  localparam int unsigned MAX_ENTRIES = 4096;
  localparam int unsigned KEY_BITS    = 31;
  localparam int unsigned NODE_COUNT  = 131072;
  localparam int unsigned ID_BITS     = 16;

  localparam int unsigned NODE_W = $clog2(NODE_COUNT);
  localparam int unsigned LINK_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned SLOT_W = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W  = LINK_W;
  localparam int unsigned LVL_W  = $clog2(KEY_BITS);
  localparam int unsigned MISS_W = $clog2(KEY_BITS + 1);
  localparam int unsigned POS_W  = 13;
  localparam int unsigned RANK_W = 13;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_RANK   = 2'd2,
    CMD_KTH    = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    RES_OK     = 2'd0,
    RES_ABSENT = 2'd1,
    RES_FULL   = 2'd2
  } res_e;

  // Micro-operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE   = 5'd0,
    OP_INIT   = 5'd1,
    OP_LOAD   = 5'd2,
    OP_SCAN   = 5'd3,
    OP_CHECK  = 5'd4,
    OP_POP    = 5'd5,
    OP_BSTART = 5'd6,
    OP_BUILD  = 5'd7,
    OP_LEAF   = 5'd8,
    OP_TAIL   = 5'd9,
    OP_FIND   = 5'd10,
    OP_LFIND  = 5'd11,
    OP_SRCH   = 5'd12,
    OP_FREE   = 5'd13,
    OP_DSTART = 5'd14,
    OP_DEC    = 5'd15,
    OP_DLEAF  = 5'd16,
    OP_KTOP   = 5'd17,
    OP_KA     = 5'd18,
    OP_KB     = 5'd19,
    OP_KLEAF  = 5'd20,
    OP_KWALK  = 5'd21,
    OP_DONE   = 5'd22
  } op_e;

  // One trie node as stored in the node memory
  typedef struct packed {
    logic [LINK_W-1:0] head;
    logic [NODE_W-1:0] right;
    logic [NODE_W-1:0] left;
    logic [CNT_W-1:0]  count;
  } node_t;

  typedef struct packed {
    op_e op;
  } dp_ctrl_t;

  typedef struct packed {
    cmd_e cmd;
    logic lvl_zero;
    logic child_zero;
    logic pool_full;
    logic free_avail;
    logic head_zero;
    logic id_match;
    logic link_end;
    logic steps_zero;
    logic pos_bad;
    logic k_bad;
    logic pick_null;
    logic out_free;
  } dp_stat_t;

endpackage

[src/btrs_ctrl.sv]
// Sequencing state machine of the binary trie rank/select unit.
module btrs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  input  btrs_pkg::cmd_e    s_cmd_i,
  output logic              s_ready_o,
  input  btrs_pkg::dp_stat_t stat_i,
  output btrs_pkg::dp_ctrl_t ctrl_o
);
  import btrs_pkg::*;

  typedef enum logic [22:0] {
    ST_INIT   = 23'h000001,
    ST_IDLE   = 23'h000002,
    ST_SCAN   = 23'h000004,
    ST_CHECK  = 23'h000008,
    ST_POP    = 23'h000010,
    ST_BSTART = 23'h000020,
    ST_BUILD  = 23'h000040,
    ST_LEAF   = 23'h000080,
    ST_TAIL   = 23'h000100,
    ST_FIND   = 23'h000200,
    ST_LFIND  = 23'h000400,
    ST_SRCH   = 23'h000800,
    ST_FREE   = 23'h001000,
    ST_DSTART = 23'h002000,
    ST_DEC    = 23'h004000,
    ST_DLEAF  = 23'h008000,
    ST_KTOP   = 23'h010000,
    ST_KA     = 23'h020000,
    ST_KB     = 23'h040000,
    ST_KLEAF  = 23'h080000,
    ST_KWALK  = 23'h100000,
    ST_DONE   = 23'h200000,
    ST_SPARE  = 23'h400000
  } state_e;

  state_e state_q, state_d;

  assign s_ready_o = (state_q == ST_IDLE);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT:   state_d = ST_IDLE;
      ST_IDLE: begin
        if (s_valid_i) begin
          case (s_cmd_i)
            CMD_INSERT: state_d = ST_SCAN;
            CMD_KTH:    state_d = ST_KTOP;
            default:    state_d = ST_FIND;
          endcase
        end
      end
      ST_SCAN:   if (stat_i.child_zero || stat_i.lvl_zero) state_d = ST_CHECK;
      ST_CHECK: begin
        if (stat_i.pool_full) state_d = ST_DONE;
        else if (stat_i.free_avail) state_d = ST_POP;
        else state_d = ST_BSTART;
      end
      ST_POP:    state_d = ST_BSTART;
      ST_BSTART: state_d = ST_BUILD;
      ST_BUILD:  if (stat_i.lvl_zero) state_d = ST_LEAF;
      ST_LEAF:   state_d = stat_i.head_zero ? ST_DONE : ST_TAIL;
      ST_TAIL:   if (stat_i.link_end) state_d = ST_DONE;
      ST_FIND: begin
        if (stat_i.child_zero) state_d = ST_DONE;
        else if (stat_i.lvl_zero) state_d = ST_LFIND;
      end
      ST_LFIND:  state_d = stat_i.head_zero ? ST_DONE : ST_SRCH;
      ST_SRCH: begin
        if (stat_i.id_match) state_d = (stat_i.cmd == CMD_RANK) ? ST_DONE : ST_FREE;
        else if (stat_i.link_end) state_d = ST_DONE;
      end
      ST_FREE:   state_d = ST_DSTART;
      ST_DSTART: state_d = ST_DEC;
      ST_DEC:    if (stat_i.lvl_zero) state_d = ST_DLEAF;
      ST_DLEAF:  state_d = ST_DONE;
      ST_KTOP:   state_d = stat_i.pos_bad ? ST_DONE : ST_KB;
      ST_KA:     state_d = ST_KB;
      ST_KB: begin
        if (stat_i.pick_null) state_d = ST_DONE;
        else state_d = stat_i.lvl_zero ? ST_KLEAF : ST_KA;
      end
      ST_KLEAF:  state_d = stat_i.k_bad ? ST_DONE : ST_KWALK;
      ST_KWALK:  if (stat_i.steps_zero || stat_i.link_end) state_d = ST_DONE;
      ST_DONE:   if (stat_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Operation for the datapath
  always_comb begin
    case (state_q)
      ST_INIT:   ctrl_o.op = OP_INIT;
      ST_IDLE:   ctrl_o.op = s_valid_i ? OP_LOAD : OP_NONE;
      ST_SCAN:   ctrl_o.op = OP_SCAN;
      ST_CHECK:  ctrl_o.op = OP_CHECK;
      ST_POP:    ctrl_o.op = OP_POP;
      ST_BSTART: ctrl_o.op = OP_BSTART;
      ST_BUILD:  ctrl_o.op = OP_BUILD;
      ST_LEAF:   ctrl_o.op = OP_LEAF;
      ST_TAIL:   ctrl_o.op = OP_TAIL;
      ST_FIND:   ctrl_o.op = OP_FIND;
      ST_LFIND:  ctrl_o.op = OP_LFIND;
      ST_SRCH:   ctrl_o.op = OP_SRCH;
      ST_FREE:   ctrl_o.op = OP_FREE;
      ST_DSTART: ctrl_o.op = OP_DSTART;
      ST_DEC:    ctrl_o.op = OP_DEC;
      ST_DLEAF:  ctrl_o.op = OP_DLEAF;
      ST_KTOP:   ctrl_o.op = OP_KTOP;
      ST_KA:     ctrl_o.op = OP_KA;
      ST_KB:     ctrl_o.op = OP_KB;
      ST_KLEAF:  ctrl_o.op = OP_KLEAF;
      ST_KWALK:  ctrl_o.op = OP_KWALK;
      ST_DONE:   ctrl_o.op = OP_DONE;
      default:   ctrl_o.op = OP_NONE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[src/btrs_dp.sv]
// Datapath of the binary trie rank/select unit: node and entry memories, walk registers.
module btrs_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  btrs_pkg::dp_ctrl_t                   ctrl_i,
  input  btrs_pkg::cmd_e                       cmd_i,
  input  logic [btrs_pkg::KEY_BITS-1:0]        score_i,
  input  logic [btrs_pkg::ID_BITS-1:0]         id_i,
  input  logic [btrs_pkg::POS_W-1:0]           pos_i,
  input  logic                                 m_ready_i,
  output logic                                 m_valid_o,
  output logic [btrs_pkg::RANK_W-1:0]          rank_o,
  output logic [btrs_pkg::ID_BITS-1:0]         id_o,
  output logic [btrs_pkg::STAT_W-1:0]          status_o,
  output btrs_pkg::dp_stat_t                   stat_o
);
  import btrs_pkg::*;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [LINK_W-1:0] lnk);
    logic [LINK_W-1:0] dec;
    dec = lnk - 1'b1;
    return dec[SLOT_W-1:0];
  endfunction

  // Memories
  node_t              node_mem [NODE_COUNT];
  logic [ID_BITS-1:0] ident_mem [MAX_ENTRIES];
  logic [LINK_W-1:0]  link_mem [MAX_ENTRIES];

  // Request and walk registers
  cmd_e               cmd_q, cmd_d;
  logic [KEY_BITS-1:0] score_q, score_d;
  logic [ID_BITS-1:0] id_q, id_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [NODE_W-1:0]  p_q, p_d;
  logic [LVL_W-1:0]   lvl_q, lvl_d;
  logic               fresh_q, fresh_d;
  logic [NODE_W-1:0]  rd_addr_q;
  node_t              nrd_q;
  logic [ID_BITS-1:0] ident_q;
  logic [LINK_W-1:0]  elink_q;
  logic [CNT_W-1:0]   higher_q, higher_d;
  logic [CNT_W-1:0]   pc_q, pc_d;
  logic               prev_left_q, prev_left_d;
  logic [MISS_W-1:0]  missing_q, missing_d;
  logic [NODE_W-1:0]  nodes_used_q, nodes_used_d;
  logic [LINK_W-1:0]  free_head_q, free_head_d;
  logic [LINK_W-1:0]  fresh_cnt_q, fresh_cnt_d;
  logic [LINK_W-1:0]  slot_q, slot_d;
  logic [NODE_W-1:0]  leaf_q, leaf_d;
  node_t              lnode_q, lnode_d;
  logic [LINK_W-1:0]  link_q, link_d;
  logic [LINK_W-1:0]  prev_q, prev_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic [CNT_W-1:0]   k_q, k_d;
  logic [NODE_W-1:0]  pr_q, pr_d;
  logic [CNT_W-1:0]   steps_q, steps_d;
  res_e               res_st_q, res_st_d;
  logic [RANK_W-1:0]  res_rank_q, res_rank_d;
  logic [ID_BITS-1:0] res_id_q, res_id_d;
  logic               out_valid_q, out_valid_d;
  res_e               out_st_q;
  logic [RANK_W-1:0]  out_rank_q;
  logic [ID_BITS-1:0] out_id_q;

  // Memory ports
  logic [NODE_W-1:0]  nraddr;
  logic               nwe;
  logic [NODE_W-1:0]  nwaddr;
  node_t              nwdata;
  logic [SLOT_W-1:0]  eraddr;
  logic               iwe;
  logic [SLOT_W-1:0]  iwaddr;
  logic               lwe;
  logic [SLOT_W-1:0]  lwaddr;
  logic [LINK_W-1:0]  lwdata;

  // Derived values
  node_t              nd;
  logic               node_ok;
  logic               bit_s;
  logic [NODE_W-1:0]  child;
  logic [NODE_W-1:0]  new_node;
  logic [NODE_W:0]    miss_sum;
  logic               go_left;
  logic [NODE_W-1:0]  pick;
  logic               out_free;
  logic               load_out;

  // Nodes beyond the fill count, the null node and fresh nodes read as zero
  assign node_ok  = (rd_addr_q != '0) && (rd_addr_q <= nodes_used_q) && !fresh_q;
  assign nd       = node_ok ? nrd_q : '0;
  assign bit_s    = score_q[lvl_q];
  assign child    = bit_s ? nd.right : nd.left;
  assign new_node = nodes_used_q + 1'b1;
  assign miss_sum = {1'b0, nodes_used_q} + (NODE_W + 1)'(missing_q);
  assign go_left  = (k_q <= nd.count);
  assign pick     = go_left ? rd_addr_q : pr_q;
  assign out_free = !out_valid_q || m_ready_i;
  assign load_out = (ctrl_i.op == OP_DONE) && out_free;

  // Status toward the controller
  always_comb begin
    stat_o.cmd        = cmd_q;
    stat_o.lvl_zero   = (lvl_q == '0);
    stat_o.child_zero = (child == '0);
    stat_o.pool_full  = (miss_sum >= (NODE_W + 1)'(NODE_COUNT)) ||
                        ((free_head_q == '0) && (fresh_cnt_q == LINK_W'(MAX_ENTRIES)));
    stat_o.free_avail = (free_head_q != '0);
    stat_o.head_zero  = (nd.head == '0);
    stat_o.id_match   = (ident_q == id_q);
    stat_o.link_end   = (elink_q == '0);
    stat_o.steps_zero = (steps_q == '0);
    stat_o.pos_bad    = (pos_q == '0) || (pos_q > nd.count);
    stat_o.k_bad      = (k_q > nd.count) || (nd.head == '0);
    stat_o.pick_null  = (pick == '0);
    stat_o.out_free   = out_free;
  end

  // Per-operation datapath actions
  always_comb begin
    cmd_d        = cmd_q;
    score_d      = score_q;
    id_d         = id_q;
    pos_d        = pos_q;
    p_d          = p_q;
    lvl_d        = lvl_q;
    fresh_d      = fresh_q;
    higher_d     = higher_q;
    pc_d         = pc_q;
    prev_left_d  = prev_left_q;
    missing_d    = missing_q;
    nodes_used_d = nodes_used_q;
    free_head_d  = free_head_q;
    fresh_cnt_d  = fresh_cnt_q;
    slot_d       = slot_q;
    leaf_d       = leaf_q;
    lnode_d      = lnode_q;
    link_d       = link_q;
    prev_d       = prev_q;
    idx_d        = idx_q;
    k_d          = k_q;
    pr_d         = pr_q;
    steps_d      = steps_q;
    res_st_d     = res_st_q;
    res_rank_d   = res_rank_q;
    res_id_d     = res_id_q;
    nraddr       = p_q;
    nwe          = 1'b0;
    nwaddr       = p_q;
    nwdata       = nd;
    eraddr       = slot_of(link_q);
    iwe          = 1'b0;
    iwaddr       = slot_of(slot_q);
    lwe          = 1'b0;
    lwaddr       = slot_of(link_q);
    lwdata       = '0;
    case (ctrl_i.op)
      OP_INIT: begin
        nwe    = 1'b1;
        nwaddr = NODE_W'(1);
        nwdata = '0;
      end
      OP_LOAD: begin
        cmd_d       = cmd_i;
        score_d     = score_i;
        id_d        = id_i;
        pos_d       = pos_i;
        nraddr      = NODE_W'(1);
        p_d         = NODE_W'(1);
        lvl_d       = LVL_W'(KEY_BITS - 1);
        fresh_d     = 1'b0;
        higher_d    = '0;
        prev_left_d = 1'b0;
        res_st_d    = RES_OK;
        res_rank_d  = '0;
        res_id_d    = '0;
      end
      // Insert pre-check: count the nodes the path still lacks
      OP_SCAN: begin
        if (child == '0) begin
          missing_d = MISS_W'(lvl_q) + 1'b1;
        end else if (lvl_q == '0) begin
          missing_d = '0;
        end else begin
          p_d    = child;
          nraddr = child;
          lvl_d  = lvl_q - 1'b1;
        end
      end
      OP_CHECK: begin
        if (stat_o.pool_full) begin
          res_st_d = RES_FULL;
        end else if (free_head_q != '0) begin
          eraddr = slot_of(free_head_q);
        end else begin
          slot_d      = fresh_cnt_q + 1'b1;
          fresh_cnt_d = fresh_cnt_q + 1'b1;
        end
      end
      OP_POP: begin
        slot_d      = free_head_q;
        free_head_d = elink_q;
      end
      OP_BSTART, OP_DSTART: begin
        nraddr  = NODE_W'(1);
        p_d     = NODE_W'(1);
        lvl_d   = LVL_W'(KEY_BITS - 1);
        fresh_d = 1'b0;
      end
      // Insert descent: raise counts, allocate missing children
      OP_BUILD: begin
        nwe          = 1'b1;
        nwdata.count = nd.count + 1'b1;
        p_d          = child;
        fresh_d      = 1'b0;
        if (child == '0) begin
          nodes_used_d = new_node;
          p_d          = new_node;
          fresh_d      = 1'b1;
          if (bit_s) nwdata.right = new_node;
          else nwdata.left = new_node;
        end
        nraddr = p_d;
        if (lvl_q != '0) lvl_d = lvl_q - 1'b1;
      end
      OP_LEAF: begin
        iwe          = 1'b1;
        lwe          = 1'b1;
        lwaddr       = slot_of(slot_q);
        lwdata       = '0;
        nwe          = 1'b1;
        nwdata.count = nd.count + 1'b1;
        if (nd.head == '0) nwdata.head = slot_q;
        link_d       = nd.head;
        eraddr       = slot_of(nd.head);
      end
      // Walk to the list tail and append
      OP_TAIL: begin
        if (elink_q == '0) begin
          lwe    = 1'b1;
          lwdata = slot_q;
        end else begin
          link_d = elink_q;
          eraddr = slot_of(elink_q);
        end
      end
      // Path lookup; entries above a left turn are counted as higher
      OP_FIND: begin
        if (prev_left_q) higher_d = higher_q + pc_q - nd.count;
        pc_d        = nd.count;
        prev_left_d = !bit_s;
        if (child == '0) begin
          res_st_d = RES_ABSENT;
        end else begin
          p_d    = child;
          nraddr = child;
          if (lvl_q != '0) lvl_d = lvl_q - 1'b1;
        end
      end
      OP_LFIND: begin
        if (prev_left_q) higher_d = higher_q + pc_q - nd.count;
        leaf_d  = p_q;
        lnode_d = nd;
        link_d  = nd.head;
        prev_d  = '0;
        idx_d   = '0;
        eraddr  = slot_of(nd.head);
        if (nd.head == '0) res_st_d = RES_ABSENT;
      end
      // Search the leaf list for the id
      OP_SRCH: begin
        if (ident_q == id_q) begin
          if (cmd_q == CMD_RANK) begin
            res_rank_d = higher_q + idx_q + 1'b1;
          end else if (prev_q == '0) begin
            nwe         = 1'b1;
            nwaddr      = leaf_q;
            nwdata      = lnode_q;
            nwdata.head = elink_q;
          end else begin
            lwe    = 1'b1;
            lwaddr = slot_of(prev_q);
            lwdata = elink_q;
          end
        end else if (elink_q == '0) begin
          res_st_d = RES_ABSENT;
        end else begin
          prev_d = link_q;
          link_d = elink_q;
          idx_d  = idx_q + 1'b1;
          eraddr = slot_of(elink_q);
        end
      end
      OP_FREE: begin
        lwe         = 1'b1;
        lwdata      = free_head_q;
        free_head_d = link_q;
      end
      OP_DEC: begin
        nwe          = 1'b1;
        nwdata.count = nd.count - 1'b1;
        p_d          = child;
        nraddr       = child;
        if (lvl_q != '0) lvl_d = lvl_q - 1'b1;
      end
      OP_DLEAF: begin
        nwe          = 1'b1;
        nwdata.count = nd.count - 1'b1;
      end
      // Order-statistic descent: read left child, then pick a side
      OP_KTOP: begin
        if (stat_o.pos_bad) begin
          res_st_d = RES_ABSENT;
        end else begin
          k_d    = pos_q;
          pr_d   = nd.right;
          nraddr = nd.left;
        end
      end
      OP_KA: begin
        pr_d   = nd.right;
        nraddr = nd.left;
      end
      OP_KB: begin
        if (pick == '0) begin
          res_st_d = RES_ABSENT;
        end else begin
          if (!go_left) k_d = k_q - nd.count;
          p_d    = pick;
          nraddr = pick;
          if (lvl_q != '0) lvl_d = lvl_q - 1'b1;
        end
      end
      OP_KLEAF: begin
        if (stat_o.k_bad) res_st_d = RES_ABSENT;
        steps_d = nd.count - k_q;
        link_d  = nd.head;
        eraddr  = slot_of(nd.head);
      end
      OP_KWALK: begin
        if (steps_q == '0) begin
          res_id_d = ident_q;
        end else if (elink_q == '0) begin
          res_st_d = RES_ABSENT;
        end else begin
          link_d  = elink_q;
          steps_d = steps_q - 1'b1;
          eraddr  = slot_of(elink_q);
        end
      end
      default: begin
      end
    endcase
  end

  // Output register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) out_valid_d = 1'b1;
    else if (m_ready_i) out_valid_d = 1'b0;
  end

  // Memories: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (nwe) node_mem[nwaddr] <= nwdata;
    nrd_q     <= node_mem[nraddr];
    rd_addr_q <= nraddr;
  end

  always_ff @(posedge clk_i) begin
    if (iwe) ident_mem[iwaddr] <= id_q;
    ident_q <= ident_mem[eraddr];
  end

  always_ff @(posedge clk_i) begin
    if (lwe) link_mem[lwaddr] <= lwdata;
    elink_q <= link_mem[eraddr];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nodes_used_q <= NODE_W'(1);
      free_head_q  <= '0;
      fresh_cnt_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      nodes_used_q <= nodes_used_d;
      free_head_q  <= free_head_d;
      fresh_cnt_q  <= fresh_cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    score_q     <= score_d;
    id_q        <= id_d;
    pos_q       <= pos_d;
    p_q         <= p_d;
    lvl_q       <= lvl_d;
    fresh_q     <= fresh_d;
    higher_q    <= higher_d;
    pc_q        <= pc_d;
    prev_left_q <= prev_left_d;
    missing_q   <= missing_d;
    slot_q      <= slot_d;
    leaf_q      <= leaf_d;
    lnode_q     <= lnode_d;
    link_q      <= link_d;
    prev_q      <= prev_d;
    idx_q       <= idx_d;
    k_q         <= k_d;
    pr_q        <= pr_d;
    steps_q     <= steps_d;
    res_st_q    <= res_st_d;
    res_rank_q  <= res_rank_d;
    res_id_q    <= res_id_d;
    if (load_out) begin
      out_st_q   <= res_st_q;
      out_rank_q <= res_rank_q;
      out_id_q   <= res_id_q;
    end
  end

  assign m_valid_o = out_valid_q;
  assign rank_o    = out_rank_q;
  assign id_o      = out_id_q;
  assign status_o  = out_st_q;

  // Node allocation stays within the pool
  a_alloc_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == OP_BUILD && child == '0) |-> (nodes_used_q < NODE_W'(NODE_COUNT - 1)))
    else $error("node allocated beyond pool");

  // The fill count only grows
  a_fill_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nodes_used_q >= $past(nodes_used_q))
    else $error("node fill count shrank");

  // The null node is never written
  a_no_null_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nwe |-> (nwaddr != '0))
    else $error("write to null node");

  // Fresh slot counter never passes the pool size
  a_fresh_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_cnt_q <= LINK_W'(MAX_ENTRIES))
    else $error("entry pool counter overflow");

endmodule

[src/binary_trie_rank_select_unit.sv]
// Top level of the binary trie rank/select unit.
// Keeps 31-bit scores in a bitwise trie (131072-node pool, 4096 entry slots) and serves one
// request at a time: insert, remove, descending rank of an id, or the id at an ascending
// position. The node memory has one registered read port and is read once per trie level
// (kth needs two reads per level); a request also walks the id list entries at its leaf.
// After reset the INIT state clears the root node before the first request is taken; unused nodes
// and entry slots are tracked by fill counts. A result waits in an output register.
module binary_trie_rank_select_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: score[30:0], entry_id[46:31], position[59:47], zero fill[63:60]
  input  logic [63:0] s_axis_tdata,
  // tuser: cmd[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: rank_out[12:0], id_out[28:13], zero fill[31:29]
  output logic [31:0] m_axis_tdata,
  // tuser: status[1:0]
  output logic [1:0]  m_axis_tuser
);
  import btrs_pkg::*;

  cmd_e               cmd;
  dp_ctrl_t           ctrl;
  dp_stat_t           stat;
  logic [RANK_W-1:0]  rank_out;
  logic [ID_BITS-1:0] id_out;
  logic [STAT_W-1:0]  status;

  assign cmd = cmd_e'(s_axis_tuser);

  btrs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_cmd_i   (cmd),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .ctrl_o    (ctrl)
  );

  btrs_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .cmd_i     (cmd),
    .score_i   (s_axis_tdata[30:0]),
    .id_i      (s_axis_tdata[46:31]),
    .pos_i     (s_axis_tdata[59:47]),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .rank_o    (rank_out),
    .id_o      (id_out),
    .status_o  (status),
    .stat_o    (stat)
  );

  assign m_axis_tdata = {3'b000, id_out, rank_out};
  assign m_axis_tuser = status;

endmodule
